@@ sv/cpre_pkg.sv @@
// Shared types and field widths for the changed pixel run encoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cpre_pkg;

  localparam int unsigned COLOR_W = 24;
  localparam int unsigned X_W     = 11;
  localparam int unsigned Y_W     = 9;
  localparam int unsigned LEN_W   = 12;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // One incoming pixel, less its position.
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               row_end;
    logic               frame_end;
    logic               redraw;
  } pixel_t;

  // One finished run.
  typedef struct packed {
    logic [COLOR_W-1:0] run_color;
    logic [LEN_W-1:0]   run_len;
    logic [Y_W-1:0]     run_y;
    logic [X_W-1:0]     run_x;
    logic               last;
  } run_t;

  // What the run builder hands to the output queue in one cycle.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

`default_nettype wire

@@ sv/cpre_frame_store.sv @@
// Frame store: one colour per pixel, synchronous (registered) read.
// A read of the entry being written in the same cycle returns the new colour.
// Depends on cpre_pkg.
`default_nettype none

module cpre_frame_store #(
  parameter int unsigned DEPTH  = 16384,
  parameter int unsigned ADDR_W = 14
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [ADDR_W-1:0]           rd_addr,
  output logic      [cpre_pkg::COLOR_W-1:0] rd_data,
  input  wire logic                        wr_en,
  input  wire logic [ADDR_W-1:0]           wr_addr,
  input  wire logic [cpre_pkg::COLOR_W-1:0] wr_data
);
  import cpre_pkg::*;

  logic [COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/cpre_run_builder.sv @@
// Run builder: compares a pixel with its stored colour and extends, opens or
// closes the current run, producing up to two finished runs. Depends on cpre_pkg.
`default_nettype none

module cpre_run_builder #(
  parameter int unsigned COL_W = 11,
  parameter int unsigned ROW_W = 9
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         advance,
  input  wire cpre_pkg::pixel_t             pixel,
  input  wire logic [COL_W-1:0]             column,
  input  wire logic [ROW_W-1:0]             row,
  input  wire logic [cpre_pkg::COLOR_W-1:0] stored_color,
  output cpre_pkg::push_t                   push,
  output cpre_pkg::run_t                    slot0,
  output cpre_pkg::run_t                    slot1
);
  import cpre_pkg::*;

  logic               run_open;
  logic [COL_W-1:0]   run_start;
  logic [COLOR_W-1:0] run_color_held;
  logic [LEN_W-1:0]   run_count;

  logic               run_open_next;
  logic [COL_W-1:0]   run_start_next;
  logic [COLOR_W-1:0] run_color_held_next;
  logic [LEN_W-1:0]   run_count_next;

  logic   changed;
  logic   open_mid;
  logic   first_v;
  logic   end_v;
  run_t   old_run;
  run_t   end_run;

  always_comb begin
    changed             = pixel.redraw || (stored_color != pixel.color);
    open_mid            = run_open;
    run_start_next      = run_start;
    run_color_held_next = run_color_held;
    run_count_next      = run_count;
    first_v             = 1'b0;

    if (changed) begin
      if (!run_open || (pixel.color != run_color_held)) begin
        // A different colour closes the open run before the new one starts.
        first_v             = run_open;
        open_mid            = 1'b1;
        run_start_next      = column;
        run_color_held_next = pixel.color;
        run_count_next      = LEN_W'(1);
      end else if (run_count != LEN_MAX) begin
        run_count_next = run_count + LEN_W'(1);
      end
    end else if (run_open) begin
      first_v  = 1'b1;
      open_mid = 1'b0;
    end

    // The end of a row or of the frame flushes whatever run is still open.
    end_v         = (pixel.row_end || pixel.frame_end) && open_mid;
    run_open_next = open_mid && !end_v;

    old_run.run_x     = X_W'(run_start);
    old_run.run_y     = Y_W'(row);
    old_run.run_len   = run_count;
    old_run.run_color = run_color_held;
    old_run.last      = !end_v;

    end_run.run_x     = X_W'(run_start_next);
    end_run.run_y     = Y_W'(row);
    end_run.run_len   = run_count_next;
    end_run.run_color = run_color_held_next;
    end_run.last      = 1'b1;

    slot0        = first_v ? old_run : end_run;
    slot1        = end_run;
    push.first   = advance && (first_v || end_v);
    push.second  = advance && first_v && end_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open       <= 1'b0;
      run_start      <= '0;
      run_color_held <= '0;
      run_count      <= '0;
    end else if (advance) begin
      run_open       <= run_open_next;
      run_start      <= run_start_next;
      run_color_held <= run_color_held_next;
      run_count      <= run_count_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/cpre_out_queue.sv @@
// Four-entry result queue that takes up to two runs a cycle and hands one a
// cycle to the output channel while out_ready is high. Depends on cpre_pkg.
`default_nettype none

module cpre_out_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cpre_pkg::push_t push,
  input  wire cpre_pkg::run_t  slot0,
  input  wire cpre_pkg::run_t  slot1,
  output logic                 room,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cpre_pkg::run_t       out_run
);
  import cpre_pkg::*;

  run_t        entries [4];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  logic [2:0]  count_next;
  logic        pop;
  logic [1:0]  wr_ptr_plus;

  assign out_valid   = (count != 3'd0);
  assign out_run     = entries[rd_ptr];
  assign pop         = out_valid && out_ready;
  assign room        = (count <= 3'd2);
  assign wr_ptr_plus = wr_ptr + 2'd1;

  always_comb begin
    count_next = count + 3'(push.first) + 3'(push.second) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      entries[wr_ptr] <= slot0;
    end
    if (push.second) begin
      entries[wr_ptr_plus] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + 2'(push.first) + 2'(push.second);
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/changed_pixel_run_encoder.sv @@
// Top level of the changed pixel run encoder.
// Instantiates cpre_frame_store, cpre_run_builder and cpre_out_queue; uses cpre_pkg.
`default_nettype none

// Pixels arrive on the s_ channel in raster order, one per transfer: colour in
// tdata, end of frame on tlast, end of row and the redraw flag in tuser. Runs
// of changed pixels of one colour leave on the m_ channel, one per transfer,
// with tlast set on the final run caused by a given pixel.
//
// Each pixel is one read-modify-write of the frame store: the store is read
// in the cycle the pixel is accepted; once the pixel sits in the stage
// registers and the queue has room, the run builder compares, updates the
// run and writes the new colour back. A read of the entry being written in
// the same cycle is forwarded inside the store.
//
// The block takes one pixel per cycle for as long as the receiver keeps
// up. A pixel can close two runs; as the output gives one run per cycle, a
// stream that closes more than one run per pixel is paced by the receiver.
// When the receiver stalls, finished runs wait in a four-entry queue and
// s_tready falls when a pixel waits and the queue cannot take two more.
//
// Reset clears the counters, the open run and the queue but not the frame
// store, so the first frame after reset must be sent with redraw set.
module changed_pixel_run_encoder #(
  parameter int unsigned FRAME_PIXELS = 16384,
  parameter int unsigned MAX_WIDTH    = 2048,
  parameter int unsigned MAX_HEIGHT   = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // pixel colour[23:0]
  input  wire logic        s_tlast,   // last_in_frame
  input  wire logic [1:0]  s_tuser,   // last_in_row, redraw_all
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // run_x[10:0], run_y[8:0], length[11:0],
                                      // run_color[23:0]
  output logic             m_tlast    // last
);
  import cpre_pkg::*;

  localparam int unsigned ADDR_W = $clog2(FRAME_PIXELS);
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);

  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(FRAME_PIXELS - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(MAX_WIDTH - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(MAX_HEIGHT - 1);

  // Position of the next pixel to arrive.
  logic [ADDR_W-1:0] pixel_address;
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;

  // The pixel whose stored colour is being read, waiting for the builder.
  logic              stage_valid;
  pixel_t            stage_pixel;
  logic [ADDR_W-1:0] stage_addr;
  logic [COL_W-1:0]  stage_col;
  logic [ROW_W-1:0]  stage_row;

  logic               in_accept;
  logic               advance;
  logic               room;
  logic [COLOR_W-1:0] stored_color;
  push_t              push;
  run_t               slot0;
  run_t               slot1;
  run_t               out_run;

  assign advance   = stage_valid && room;
  assign s_tready  = !stage_valid || room;
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_address <= '0;
      column_count  <= '0;
      row_count     <= '0;
    end else if (in_accept) begin
      if (s_tlast) begin
        pixel_address <= '0;
        column_count  <= '0;
        row_count     <= '0;
      end else begin
        pixel_address <= (pixel_address == ADDR_LAST) ? '0 : pixel_address + ADDR_W'(1);
        if (s_tuser[0]) begin
          column_count <= '0;
          if (row_count != ROW_LAST) begin
            row_count <= row_count + ROW_W'(1);
          end
        end else if (column_count != COL_LAST) begin
          column_count <= column_count + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_pixel.color     <= s_tdata;
      stage_pixel.row_end   <= s_tuser[0];
      stage_pixel.frame_end <= s_tlast;
      stage_pixel.redraw    <= s_tuser[1];
      stage_addr            <= pixel_address;
      stage_col             <= column_count;
      stage_row             <= row_count;
    end
  end

  cpre_frame_store #(
    .DEPTH  (FRAME_PIXELS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (pixel_address),
    .rd_data (stored_color),
    .wr_en   (advance),
    .wr_addr (stage_addr),
    .wr_data (stage_pixel.color)
  );

  cpre_run_builder #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_builder (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .pixel        (stage_pixel),
    .column       (stage_col),
    .row          (stage_row),
    .stored_color (stored_color),
    .push         (push),
    .slot0        (slot0),
    .slot1        (slot1)
  );

  cpre_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .slot0     (slot0),
    .slot1     (slot1),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_run   (out_run)
  );

  assign m_tdata = {out_run.run_color, out_run.run_len, out_run.run_y, out_run.run_x};
  assign m_tlast = out_run.last;

endmodule

`default_nettype wire
